FILE: hdl/srbp_pkg.sv
package srbp_pkg;

    localparam int READ_LENGTH    = 100;
    localparam int STORE_WORDS    = 7;
    localparam int BASES_PER_WORD = 16;
    localparam int STORE_BASES    = STORE_WORDS * BASES_PER_WORD;
    localparam int EFF_LEN        = (READ_LENGTH > STORE_BASES) ? STORE_BASES : READ_LENGTH;
    localparam int EMIT_WORDS     = (EFF_LEN + BASES_PER_WORD - 1) / BASES_PER_WORD;

    localparam int WORD_W       = 32;
    localparam int CODE_W       = 2;
    localparam int SLOT_W       = $clog2(BASES_PER_WORD);
    localparam int STORE_ADDR_W = $clog2(STORE_WORDS);
    localparam int POS_W        = $clog2(STORE_BASES + 1);
    localparam int EMIT_CNT_W   = $clog2(EMIT_WORDS + 1);
    localparam int INDEX_W      = 3;
    localparam int BYTE_W       = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;

    localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C       = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
    localparam logic [BYTE_W-1:0] CH_T       = 8'h54;
    localparam logic [BYTE_W-1:0] CH_N       = 8'h4E;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_BASES,
        PH_AFTER,
        PH_PLUS,
        PH_QUAL
    } phase_t;

    typedef struct packed {
        logic                  busy;
        logic [EMIT_CNT_W-1:0] ptr;
    } emit_status_t;

    function automatic logic [CODE_W-1:0] base_code(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] code;
        case (b)
            CH_C:    code = 2'd1;
            CH_G:    code = 2'd2;
            CH_T:    code = 2'd3;
            CH_N:    code = 2'd2;
            default: code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/srbp_store.sv
module srbp_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [srbp_pkg::STORE_ADDR_W-1:0]   wr_addr,
    input  logic [srbp_pkg::WORD_W-1:0]         wr_data,
    input  logic [srbp_pkg::STORE_ADDR_W-1:0]   rda_addr,
    output logic [srbp_pkg::WORD_W-1:0]         rda_data,
    input  logic [srbp_pkg::STORE_ADDR_W-1:0]   rdb_addr,
    output logic [srbp_pkg::WORD_W-1:0]         rdb_data
);

    logic [srbp_pkg::WORD_W-1:0]       mem [srbp_pkg::STORE_WORDS];
    logic [srbp_pkg::STORE_WORDS-1:0]  valid_reg;
    logic [srbp_pkg::WORD_W-1:0]       rda_reg;
    logic [srbp_pkg::WORD_W-1:0]       rdb_reg;
    logic                              rda_vld_reg;
    logic                              rdb_vld_reg;
    logic [srbp_pkg::STORE_ADDR_W-1:0] rda_addr_reg;
    logic                              fwd_vld_reg;
    logic [srbp_pkg::STORE_ADDR_W-1:0] fwd_addr_reg;
    logic [srbp_pkg::WORD_W-1:0]       fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rda_reg      <= mem[rda_addr];
        rdb_reg      <= mem[rdb_addr];
        rda_addr_reg <= rda_addr;
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            rda_vld_reg <= 1'b0;
            rdb_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rda_vld_reg <= valid_reg[rda_addr];
            rdb_vld_reg <= valid_reg[rdb_addr];
            fwd_vld_reg <= wr_en;
        end
    end

    // A write in the cycle of the read is not yet in the array, so it is forwarded.
    always_comb begin
        if (fwd_vld_reg && (fwd_addr_reg == rda_addr_reg)) begin
            rda_data = fwd_data_reg;
        end else if (rda_vld_reg) begin
            rda_data = rda_reg;
        end else begin
            rda_data = '0;
        end
        rdb_data = rdb_vld_reg ? rdb_reg : '0;
    end

endmodule

FILE: hdl/srbp_emit.sv
module srbp_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    output srbp_pkg::emit_status_t              status,
    output logic [srbp_pkg::STORE_ADDR_W-1:0]   rd_addr,
    input  logic [srbp_pkg::WORD_W-1:0]         rd_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srbp_pkg::M_TDATA_W-1:0]      m_tdata, // packed_word[31:0], word_index[34:32]
    output logic                                m_tlast  // last_word
);

    logic [srbp_pkg::EMIT_CNT_W-1:0] ptr_reg;
    logic [srbp_pkg::EMIT_CNT_W-1:0] ptr_next;
    logic                            pend_reg;
    logic [srbp_pkg::EMIT_CNT_W-1:0] pend_idx_reg;
    logic                            out_vld_reg;
    logic [srbp_pkg::WORD_W-1:0]     out_word_reg;
    logic [srbp_pkg::INDEX_W-1:0]    out_idx_reg;
    logic                            out_last_reg;
    logic                            busy;
    logic                            issue;

    assign busy  = (ptr_reg != srbp_pkg::EMIT_CNT_W'(srbp_pkg::EMIT_WORDS));
    assign issue = busy && !pend_reg && (!out_vld_reg || m_tready);

    always_comb begin
        ptr_next = ptr_reg;
        if (start) begin
            ptr_next = '0;
        end else if (issue) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= srbp_pkg::EMIT_CNT_W'(srbp_pkg::EMIT_WORDS);
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            ptr_reg  <= ptr_next;
            pend_reg <= issue;
            if (pend_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= ptr_reg;
        if (pend_reg) begin
            out_word_reg <= rd_data;
            out_idx_reg  <= srbp_pkg::INDEX_W'(pend_idx_reg);
            out_last_reg <= (pend_idx_reg == srbp_pkg::EMIT_CNT_W'(srbp_pkg::EMIT_WORDS - 1));
        end
    end

    assign rd_addr     = ptr_reg[srbp_pkg::STORE_ADDR_W-1:0];
    assign status.busy = busy;
    assign status.ptr  = ptr_reg;
    assign m_tvalid    = out_vld_reg;
    assign m_tdata     = {5'd0, out_idx_reg, out_word_reg};
    assign m_tlast     = out_last_reg;

endmodule

FILE: hdl/sequence_record_base_packer_core.sv
// Accepts one byte beat per cycle; a record's words leave one beat at a time after the beat
// that completes the record, each read from the store and registered before it is offered.
// Input stalls while a new record completes before every word of the previous one has
// been read from the store, or while a base targets a store word that the word reader
// has not yet fetched.
// Reset is synchronous and active low; the read store reads as zero until each word is
// first written, so no clearing pass follows reset.
module sequence_record_base_packer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [srbp_pkg::S_TDATA_W-1:0]     s_tdata, // text_byte[7:0]
    input  logic                               s_tlast, // end_of_file
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [srbp_pkg::M_TDATA_W-1:0]     m_tdata, // packed_word[31:0], word_index[34:32]
    output logic                               m_tlast  // last_word
);

    srbp_pkg::phase_t                  phase_reg;
    srbp_pkg::phase_t                  phase_next;
    logic                              halted_reg;
    logic                              halted_next;
    logic [srbp_pkg::POS_W-1:0]        pos_reg;
    logic [srbp_pkg::POS_W-1:0]        pos_next;
    logic                              s1_vld_reg;
    logic [srbp_pkg::STORE_ADDR_W-1:0] s1_addr_reg;
    logic [srbp_pkg::SLOT_W-1:0]       s1_slot_reg;
    logic [srbp_pkg::CODE_W-1:0]       s1_code_reg;

    logic [srbp_pkg::BYTE_W-1:0]       b;
    logic                              accept;
    logic                              need_emit;
    logic                              is_put;
    logic                              stall;
    logic [srbp_pkg::STORE_ADDR_W-1:0] word;
    logic [srbp_pkg::WORD_W-1:0]       old_word;
    logic [srbp_pkg::WORD_W-1:0]       new_word;
    logic [4:0]                        shift;
    logic [srbp_pkg::STORE_ADDR_W-1:0] emit_addr;
    logic [srbp_pkg::WORD_W-1:0]       emit_data;
    srbp_pkg::emit_status_t            emit_st;

    assign b    = s_tdata[srbp_pkg::BYTE_W-1:0];
    assign word = srbp_pkg::STORE_ADDR_W'(pos_reg >> srbp_pkg::SLOT_W);

    always_comb begin
        need_emit = 1'b0;
        is_put    = 1'b0;
        if (!halted_reg) begin
            if (s_tlast) begin
                need_emit = (phase_reg == srbp_pkg::PH_AFTER);
            end else begin
                need_emit = ((phase_reg == srbp_pkg::PH_AFTER) && (b != srbp_pkg::CH_PLUS))
                         || ((phase_reg == srbp_pkg::PH_QUAL) && (b == srbp_pkg::CH_NEWLINE));
                is_put    = (phase_reg == srbp_pkg::PH_BASES) && (b != srbp_pkg::CH_NEWLINE)
                         && (pos_reg < srbp_pkg::POS_W'(srbp_pkg::EFF_LEN));
            end
        end
    end

    assign stall = emit_st.busy
                && (need_emit
                    || (is_put && (srbp_pkg::EMIT_CNT_W'(word) >= emit_st.ptr)));
    assign s_tready = !stall;
    assign accept   = s_tvalid && !stall;

    always_comb begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        pos_next    = pos_reg;
        if (accept) begin
            if (s_tlast) begin
                phase_next  = srbp_pkg::PH_START;
                halted_next = 1'b0;
            end else if (!halted_reg) begin
                unique case (phase_reg) inside
                    srbp_pkg::PH_START, srbp_pkg::PH_AFTER: begin
                        if (phase_reg == srbp_pkg::PH_AFTER && b == srbp_pkg::CH_PLUS) begin
                            phase_next = srbp_pkg::PH_PLUS;
                        end else if (b == srbp_pkg::CH_HEADER) begin
                            phase_next = srbp_pkg::PH_HEADER;
                        end else begin
                            phase_next  = srbp_pkg::PH_START;
                            halted_next = 1'b1;
                        end
                    end
                    srbp_pkg::PH_HEADER: begin
                        if (b == srbp_pkg::CH_NEWLINE) begin
                            phase_next = srbp_pkg::PH_BASES;
                            pos_next   = '0;
                        end
                    end
                    srbp_pkg::PH_BASES: begin
                        if (b == srbp_pkg::CH_NEWLINE) begin
                            phase_next = srbp_pkg::PH_AFTER;
                        end else if (is_put) begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    srbp_pkg::PH_PLUS: begin
                        if (b == srbp_pkg::CH_NEWLINE) begin
                            phase_next = srbp_pkg::PH_QUAL;
                        end
                    end
                    srbp_pkg::PH_QUAL: begin
                        if (b == srbp_pkg::CH_NEWLINE) begin
                            phase_next = srbp_pkg::PH_START;
                        end
                    end
                    default: begin
                        phase_next = srbp_pkg::PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= srbp_pkg::PH_START;
            halted_reg <= 1'b0;
            pos_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
            pos_reg    <= pos_next;
            s1_vld_reg <= accept && is_put;
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= word;
        s1_slot_reg <= pos_reg[srbp_pkg::SLOT_W-1:0];
        s1_code_reg <= srbp_pkg::base_code(b);
    end

    assign shift    = {~s1_slot_reg, 1'b0};
    assign new_word = (old_word & ~(srbp_pkg::WORD_W'(2'b11) << shift))
                    | (srbp_pkg::WORD_W'(s1_code_reg) << shift);

    srbp_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s1_vld_reg),
        .wr_addr  (s1_addr_reg),
        .wr_data  (new_word),
        .rda_addr (word),
        .rda_data (old_word),
        .rdb_addr (emit_addr),
        .rdb_data (emit_data)
    );

    srbp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && need_emit),
        .status   (emit_st),
        .rd_addr  (emit_addr),
        .rd_data  (emit_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
